// File: design/sam_pkg.sv
// Package for the suffix automaton match core: sizes, opcodes, beat types.
// No dependencies.
package sam_pkg;

    localparam int MAX_TEXT = 1024;
    localparam int ALPHABET = 26;
    localparam int NODES    = 2 * MAX_TEXT;
    localparam int NODE_W   = $clog2(NODES);
    localparam int LEN_W    = $clog2(MAX_TEXT + 1);
    localparam int SYM_W    = 5;
    localparam int ROW_W    = ALPHABET * NODE_W;

    localparam logic [NODE_W-1:0] ROOT    = NODE_W'(1);
    localparam logic [NODE_W-1:0] NO_NODE = '0;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_APPEND  = 2'd1,
        OP_RESTART = 2'd2,
        OP_MATCH   = 2'd3
    } opcode_t;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [SYM_W-1:0] symbol;
    } req_t;

    typedef struct packed {
        logic [LEN_W-1:0] match_len;
        logic [LEN_W-1:0] best_len;
        logic             text_full;
    } rsp_t;

    typedef struct packed {
        logic [NODE_W-1:0] link;
        logic [LEN_W-1:0]  len;
    } node_info_t;

endpackage

// File: design/sam_ram.sv
// Generic single-port synchronous RAM, registered read.
// No dependencies.
module sam_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 22
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata <= mem[addr];
        end
    end

endmodule

// File: design/suffix_automaton_match_core.sv
// Suffix automaton match core: online build from reference symbols, query match.
// Match follows suffix links until an edge on the symbol is found or the root is reached;
// append walks suffix links adding edges to the new node, and may make a clone and
// redirect edges to it. Restart and rejected beats go straight to the response.
// Flow: one beat in flight; req_ready is high only in the idle state.
// Reset: an init state writes the root row; nodes above the count are never read.
module suffix_automaton_match_core
    import sam_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    typedef enum logic [3:0] {
        ST_INIT, ST_CLEAR, ST_IDLE, ST_AP_NEW, ST_AP_RD, ST_AP_CHK, ST_AP_RQ, ST_AP_Q,
        ST_AP_CL, ST_AP_CL2, ST_AP_RRD, ST_AP_RCHK, ST_AP_FIN,
        ST_MT_RD, ST_MT_CHK, ST_RESP
    } state_t;

    state_t             state_reg, state_next;
    logic [SYM_W-1:0]   sym_reg, sym_next;
    logic               full_reg, full_next;
    logic [NODE_W-1:0]  last_reg, last_next;
    logic [LEN_W-1:0]   last_len_reg, last_len_next;
    logic [NODE_W-1:0]  count_reg, count_next;
    logic [NODE_W-1:0]  cur_reg, cur_next;
    logic [LEN_W-1:0]   cur_len_reg, cur_len_next;
    logic [LEN_W-1:0]   best_reg, best_next;
    logic [NODE_W-1:0]  p_reg, p_next;
    logic [NODE_W-1:0]  np_reg, np_next;
    logic [NODE_W-1:0]  q_reg, q_next;
    logic [NODE_W-1:0]  nq_reg, nq_next;
    logic [LEN_W-1:0]   plen_reg, plen_next;
    logic [LEN_W-1:0]   qlen_reg, qlen_next;
    logic [NODE_W-1:0]  qlink_reg, qlink_next;
    logic [NODE_W-1:0]  lnp_reg, lnp_next;
    logic               follow_reg, follow_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg, rsp_next;

    logic               edge_we;
    logic [NODE_W-1:0]  edge_addr;
    logic [ROW_W-1:0]   edge_wdata;
    logic [ROW_W-1:0]   edge_rdata;
    logic               info_we;
    logic [NODE_W-1:0]  info_addr;
    node_info_t         info_wdata;
    node_info_t         info_rdata;

    logic [NODE_W-1:0]  col;
    logic [ROW_W-1:0]   row_mod;
    logic [LEN_W-1:0]   len_now;
    logic [LEN_W-1:0]   mlen;

    sam_ram #(.DEPTH(NODES), .WIDTH(ROW_W)) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .addr  (edge_addr),
        .wdata (edge_wdata),
        .rdata (edge_rdata)
    );

    sam_ram #(.DEPTH(NODES), .WIDTH($bits(node_info_t))) u_info_ram (
        .clk   (clk),
        .we    (info_we),
        .addr  (info_addr),
        .wdata (info_wdata),
        .rdata (info_rdata)
    );

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign col       = edge_rdata[sym_reg * NODE_W +: NODE_W];
    assign len_now   = follow_reg ? info_rdata.len : cur_len_reg;

    always_comb
    begin
        state_next     = state_reg;
        sym_next       = sym_reg;
        full_next      = full_reg;
        last_next      = last_reg;
        last_len_next  = last_len_reg;
        count_next     = count_reg;
        cur_next       = cur_reg;
        cur_len_next   = cur_len_reg;
        best_next      = best_reg;
        p_next         = p_reg;
        np_next        = np_reg;
        q_next         = q_reg;
        nq_next        = nq_reg;
        plen_next      = plen_reg;
        qlen_next      = qlen_reg;
        qlink_next     = qlink_reg;
        lnp_next       = lnp_reg;
        follow_next    = follow_reg;
        row_next       = row_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        edge_we        = 1'b0;
        edge_addr      = p_reg;
        edge_wdata     = '0;
        info_we        = 1'b0;
        info_addr      = p_reg;
        info_wdata     = '0;
        row_mod        = edge_rdata;
        mlen           = len_now;

        case (state_reg)
            ST_INIT:
            begin
                edge_we    = 1'b1;
                edge_addr  = ROOT;
                info_we    = 1'b1;
                info_addr  = ROOT;
                state_next = ST_IDLE;
            end
            ST_CLEAR:
            begin
                edge_we    = 1'b1;
                edge_addr  = ROOT;
                info_we    = 1'b1;
                info_addr  = ROOT;
                state_next = ST_RESP;
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    sym_next  = req.symbol;
                    full_next = 1'b0;
                    case (opcode_t'(req.opcode))
                        OP_CLEAR:
                        begin
                            last_next     = ROOT;
                            last_len_next = '0;
                            count_next    = ROOT;
                            cur_next      = ROOT;
                            cur_len_next  = '0;
                            best_next     = '0;
                            state_next    = ST_CLEAR;
                        end
                        OP_APPEND:
                        begin
                            if (req.symbol >= SYM_W'(ALPHABET))
                            begin
                                state_next = ST_RESP;
                            end
                            else if (last_len_reg >= LEN_W'(MAX_TEXT) ||
                                     count_reg >= NODE_W'(NODES - 1))
                            begin
                                full_next  = 1'b1;
                                state_next = ST_RESP;
                            end
                            else
                            begin
                                np_next    = count_reg + NODE_W'(1);
                                count_next = count_reg + NODE_W'(1);
                                p_next     = last_reg;
                                state_next = ST_AP_NEW;
                            end
                        end
                        OP_RESTART:
                        begin
                            cur_next     = ROOT;
                            cur_len_next = '0;
                            best_next    = '0;
                            state_next   = ST_RESP;
                        end
                        default:
                        begin
                            if (req.symbol >= SYM_W'(ALPHABET))
                            begin
                                cur_next     = ROOT;
                                cur_len_next = '0;
                                state_next   = ST_RESP;
                            end
                            else
                            begin
                                p_next      = cur_reg;
                                follow_next = 1'b0;
                                state_next  = ST_MT_RD;
                            end
                        end
                    endcase
                end
            end
            ST_AP_NEW:
            begin
                edge_we    = 1'b1;
                edge_addr  = np_reg;
                state_next = ST_AP_RD;
            end
            ST_AP_RD:
            begin
                if (p_reg == NO_NODE)
                begin
                    lnp_next   = ROOT;
                    state_next = ST_AP_FIN;
                end
                else
                begin
                    state_next = ST_AP_CHK;
                end
            end
            ST_AP_CHK:
            begin
                if (col == NO_NODE)
                begin
                    row_mod[sym_reg * NODE_W +: NODE_W] = np_reg;
                    edge_we    = 1'b1;
                    edge_wdata = row_mod;
                    p_next     = info_rdata.link;
                    state_next = ST_AP_RD;
                end
                else
                begin
                    q_next     = col;
                    plen_next  = info_rdata.len;
                    state_next = ST_AP_RQ;
                end
            end
            ST_AP_RQ:
            begin
                edge_addr  = q_reg;
                info_addr  = q_reg;
                state_next = ST_AP_Q;
            end
            ST_AP_Q:
            begin
                row_next   = edge_rdata;
                qlen_next  = info_rdata.len;
                qlink_next = info_rdata.link;
                if (info_rdata.len == plen_reg + LEN_W'(1))
                begin
                    lnp_next   = q_reg;
                    state_next = ST_AP_FIN;
                end
                else
                begin
                    nq_next    = count_reg + NODE_W'(1);
                    count_next = count_reg + NODE_W'(1);
                    state_next = ST_AP_CL;
                end
            end
            ST_AP_CL:
            begin
                edge_we         = 1'b1;
                edge_addr       = nq_reg;
                edge_wdata      = row_reg;
                info_we         = 1'b1;
                info_addr       = nq_reg;
                info_wdata.link = qlink_reg;
                info_wdata.len  = plen_reg + LEN_W'(1);
                state_next      = ST_AP_CL2;
            end
            ST_AP_CL2:
            begin
                info_we         = 1'b1;
                info_addr       = q_reg;
                info_wdata.link = nq_reg;
                info_wdata.len  = qlen_reg;
                lnp_next        = nq_reg;
                state_next      = ST_AP_RRD;
            end
            ST_AP_RRD:
            begin
                state_next = (p_reg == NO_NODE) ? ST_AP_FIN : ST_AP_RCHK;
            end
            ST_AP_RCHK:
            begin
                if (col == q_reg)
                begin
                    row_mod[sym_reg * NODE_W +: NODE_W] = nq_reg;
                    edge_we    = 1'b1;
                    edge_wdata = row_mod;
                    p_next     = info_rdata.link;
                    state_next = ST_AP_RRD;
                end
                else
                begin
                    state_next = ST_AP_FIN;
                end
            end
            ST_AP_FIN:
            begin
                info_we         = 1'b1;
                info_addr       = np_reg;
                info_wdata.link = lnp_reg;
                info_wdata.len  = last_len_reg + LEN_W'(1);
                last_next       = np_reg;
                last_len_next   = last_len_reg + LEN_W'(1);
                state_next      = ST_RESP;
            end
            ST_MT_RD:
            begin
                state_next = ST_MT_CHK;
            end
            ST_MT_CHK:
            begin
                follow_next = 1'b0;
                if (col != NO_NODE)
                begin
                    mlen         = len_now + LEN_W'(1);
                    cur_next     = col;
                    cur_len_next = mlen;
                    state_next   = ST_RESP;
                end
                else if (p_reg > ROOT)
                begin
                    p_next       = info_rdata.link;
                    cur_len_next = len_now;
                    follow_next  = 1'b1;
                    state_next   = ST_MT_RD;
                end
                else
                begin
                    cur_next     = p_reg;
                    cur_len_next = len_now;
                    state_next   = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.match_len = cur_len_reg;
                    rsp_next.best_len  = (cur_len_reg > best_reg) ? cur_len_reg : best_reg;
                    rsp_next.text_full = full_reg;
                    best_next          = rsp_next.best_len;
                    rsp_valid_next     = 1'b1;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            full_reg      <= 1'b0;
            last_reg      <= ROOT;
            last_len_reg  <= '0;
            count_reg     <= ROOT;
            cur_reg       <= ROOT;
            cur_len_reg   <= '0;
            best_reg      <= '0;
            follow_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            full_reg      <= full_next;
            last_reg      <= last_next;
            last_len_reg  <= last_len_next;
            count_reg     <= count_next;
            cur_reg       <= cur_next;
            cur_len_reg   <= cur_len_next;
            best_reg      <= best_next;
            follow_reg    <= follow_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg   <= sym_next;
        p_reg     <= p_next;
        np_reg    <= np_next;
        q_reg     <= q_next;
        nq_reg    <= nq_next;
        plen_reg  <= plen_next;
        qlen_reg  <= qlen_next;
        qlink_reg <= qlink_next;
        lnp_reg   <= lnp_next;
        row_reg   <= row_next;
        rsp_reg   <= rsp_next;
    end

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NODE_W'(NODES - 1))
        else $error("node count beyond capacity");

    a_cursor_node: assert property (@(posedge clk) disable iff (!rst_n)
        cur_reg != NO_NODE)
        else $error("cursor on null node");

    a_text_cap: assert property (@(posedge clk) disable iff (!rst_n)
        last_len_reg <= LEN_W'(MAX_TEXT))
        else $error("stored text beyond capacity");

    a_edge_row0: assert property (@(posedge clk) disable iff (!rst_n)
        edge_we |-> edge_addr != NO_NODE)
        else $error("edge write to null node");

endmodule

// File: test/tb_suffix_automaton_match_core.sv
// Testbench for suffix_automaton_match_core: directed table, random beats, then a fill to
// capacity; checked against a behavioral suffix automaton predictor. Depends on sam_pkg and the core.
`timescale 1ns / 1ps

module tb_suffix_automaton_match_core;
    import sam_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    suffix_automaton_match_core dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    always #5 clk = ~clk;

    // predictor state
    int unsigned trans [NODES][ALPHABET];
    int unsigned slink [NODES];
    int unsigned nlen [NODES];
    int unsigned tail_node, nodes_used, cur_node, cur_len, best_len_q;

    rsp_t expected_rsp [$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_recv = 1'b0;
    bit hold_open = 1'b0;

    function automatic void sa_clear();
        for (int n = 0; n < NODES; n++)
        begin
            slink[n] = 0;
            nlen[n] = 0;
            for (int c = 0; c < ALPHABET; c++)
                trans[n][c] = 0;
        end
        tail_node = 1;
        nodes_used = 1;
        cur_node = 1;
        cur_len = 0;
        best_len_q = 0;
    endfunction

    function automatic bit sa_extend(int unsigned c);
        int unsigned p, np, q, nq;
        if (nlen[tail_node] >= MAX_TEXT || nodes_used + 2 >= NODES + 1)
            return 1'b1;
        p = tail_node;
        nodes_used++;
        np = nodes_used;
        nlen[np] = nlen[p] + 1;
        slink[np] = 0;
        while (p != 0 && trans[p][c] == 0)
        begin
            trans[p][c] = np;
            p = slink[p];
        end
        if (p == 0)
            slink[np] = 1;
        else
        begin
            q = trans[p][c];
            if (nlen[q] == nlen[p] + 1)
                slink[np] = q;
            else
            begin
                nodes_used++;
                nq = nodes_used;
                trans[nq] = trans[q];
                slink[nq] = slink[q];
                nlen[nq] = nlen[p] + 1;
                slink[q] = nq;
                slink[np] = nq;
                while (p != 0 && trans[p][c] == q)
                begin
                    trans[p][c] = nq;
                    p = slink[p];
                end
            end
        end
        tail_node = np;
        return 1'b0;
    endfunction

    function automatic void sa_match(int unsigned c);
        int unsigned p, l;
        p = cur_node;
        l = cur_len;
        if (c >= ALPHABET)
        begin
            p = 1;
            l = nlen[1];
        end
        else
        begin
            while (p > 1 && trans[p][c] == 0)
            begin
                p = slink[p];
                l = nlen[p];
            end
            if (trans[p][c] != 0)
            begin
                p = trans[p][c];
                l++;
            end
        end
        cur_node = p;
        cur_len = l;
        if (l > best_len_q)
            best_len_q = l;
    endfunction

    function automatic rsp_t sa_step(req_t r);
        rsp_t o;
        bit full;
        full = 1'b0;
        case (opcode_t'(r.opcode))
            OP_CLEAR: sa_clear();
            OP_APPEND: if (r.symbol < ALPHABET) full = sa_extend(r.symbol);
            OP_RESTART:
            begin
                cur_node = 1;
                cur_len = 0;
                best_len_q = 0;
            end
            default: sa_match(r.symbol);
        endcase
        o.match_len = LEN_W'(cur_len);
        o.best_len = LEN_W'(best_len_q);
        o.text_full = full;
        return o;
    endfunction

    task automatic send_beat(req_t r);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        expected_rsp.push_back(sa_step(r));
    endtask

    task automatic send_beat_expect(req_t r, rsp_t want);
        rsp_t got;
        got = sa_step(r);
        if (got !== want)
        begin
            $display("%0t predictor table mismatch: expected %p actual %p", $time, want, got);
            errors++;
        end
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        expected_rsp.push_back(want);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsp.size() == 0)
                begin
                    $display("%0t unexpected beat: actual %p", $time, rsp);
                    errors++;
                end
                else
                begin
                    rsp_t e;
                    e = expected_rsp.pop_front();
                    if (rsp.match_len !== e.match_len)
                    begin
                        $display("%0t match_len: expected %0d actual %0d",
                                 $time, e.match_len, rsp.match_len);
                        errors++;
                    end
                    if (rsp.best_len !== e.best_len)
                    begin
                        $display("%0t best_len: expected %0d actual %0d",
                                 $time, e.best_len, rsp.best_len);
                        errors++;
                    end
                    if (rsp.text_full !== e.text_full)
                    begin
                        $display("%0t text_full: expected %0d actual %0d",
                                 $time, e.text_full, rsp.text_full);
                        errors++;
                    end
                end
            end
            rsp_ready <= !hold_recv && !(recv_stall_pct > 0 &&
                         $urandom_range(99, 0) < recv_stall_pct);
        end
    end

    // long receiver hold-off, counted here
    initial
    begin
        wait (hold_open);
        hold_recv = 1'b1;
        repeat (300) @(posedge clk);
        hold_recv = 1'b0;
    end

    typedef struct {
        opcode_t op;
        int unsigned sym;
        bit check;
        int unsigned ml;
        int unsigned bl;
        bit tf;
    } stim_row_t;

    stim_row_t directed [] = '{
        '{OP_MATCH,   0,  1, 0, 0, 0},
        '{OP_APPEND,  0,  0, 0, 0, 0},
        '{OP_APPEND,  1,  0, 0, 0, 0},
        '{OP_APPEND,  0,  0, 0, 0, 0},
        '{OP_APPEND,  1,  0, 0, 0, 0},
        '{OP_APPEND,  25, 0, 0, 0, 0},
        '{OP_APPEND,  26, 1, 0, 0, 0},
        '{OP_APPEND,  31, 1, 0, 0, 0},
        '{OP_APPEND,  0,  0, 0, 0, 0},
        '{OP_APPEND,  0,  0, 0, 0, 0},
        '{OP_MATCH,   0,  0, 0, 0, 0},
        '{OP_MATCH,   1,  0, 0, 0, 0},
        '{OP_MATCH,   0,  0, 0, 0, 0},
        '{OP_MATCH,   1,  0, 0, 0, 0},
        '{OP_MATCH,   3,  0, 0, 0, 0},
        '{OP_MATCH,   25, 0, 0, 0, 0},
        '{OP_MATCH,   31, 0, 0, 0, 0},
        '{OP_MATCH,   0,  0, 0, 0, 0},
        '{OP_RESTART, 0,  1, 0, 0, 0},
        '{OP_MATCH,   30, 1, 0, 0, 0},
        '{OP_CLEAR,   31, 1, 0, 0, 0},
        '{OP_MATCH,   0,  1, 0, 0, 0}
    };

    function automatic req_t mk(opcode_t op, int unsigned s);
        req_t r;
        r.opcode = op;
        r.symbol = SYM_W'(s);
        return r;
    endfunction

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_phase(int n, int idle, int stall, int alpha);
        int k;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        k = 0;
        while (k < n)
        begin
            int unsigned pick;
            pick = $urandom_range(99, 0);
            if (pick < 2)
                send_beat(mk(OP_CLEAR, $urandom_range(31, 0)));
            else if (pick < 40)
                send_beat(mk(OP_APPEND, pick < 39 ? $urandom_range(alpha - 1, 0)
                                                   : $urandom_range(31, 0)));
            else if (pick < 44)
                send_beat(mk(OP_RESTART, $urandom_range(31, 0)));
            else
                send_beat(mk(OP_MATCH, pick < 98 ? $urandom_range(alpha - 1, 0)
                                                  : $urandom_range(31, 0)));
            k++;
        end
    endtask

    initial
    begin
        sa_clear();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            req_t r;
            r = mk(directed[i].op, directed[i].sym);
            if (directed[i].check)
                send_beat_expect(r, '{LEN_W'(directed[i].ml), LEN_W'(directed[i].bl),
                                      directed[i].tf});
            else
                send_beat(r);
        end

        random_phase(250, 0, 0, 3);
        random_phase(200, 54, 0, 26);
        random_phase(200, 0, 54, 2);
        hold_open = 1'b1;
        random_phase(150, 8, 8, 4);
        // sender pauses until everything is back
        wait_drained();
        random_phase(150, 0, 0, 26);

        // fill to capacity, then overflow
        send_idle_pct = 0;
        recv_stall_pct = 10;
        send_beat(mk(OP_CLEAR, 0));
        for (int i = 0; i < MAX_TEXT + 3; i++)
            send_beat(mk(OP_APPEND, $urandom_range(2, 0)));
        send_beat(mk(OP_APPEND, 25));
        for (int i = 0; i < 40; i++)
            send_beat(mk(OP_MATCH, $urandom_range(2, 0)));
        send_beat(mk(OP_RESTART, 0));
        for (int i = 0; i < 40; i++)
            send_beat(mk(OP_MATCH, $urandom_range(25, 0)));

        wait_drained();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #100ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
